[rtl/kfr_pkg.sv]
`default_nettype none

package kfr_pkg;

   localparam int unsigned DATA_W      = 32;
   localparam int unsigned PROD_W      = 2 * DATA_W;
   localparam int unsigned DEN_W       = DATA_W + 1;
   localparam int unsigned CSR_INDEX_W = 2;
   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned DIV_STEPS   = PROD_W;
   localparam int unsigned DIV_CNT_W   = $clog2(DIV_STEPS);

   localparam logic [CSR_INDEX_W-1:0] CSR_INITIAL_VARIANCE     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MOTION_VARIANCE      = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MEASUREMENT_VARIANCE = 2'd2;

   localparam logic [DATA_W-1:0] INITIAL_VARIANCE_RST     = 32'd65536000;
   localparam logic [DATA_W-1:0] MOTION_VARIANCE_RST      = 32'd262144;
   localparam logic [DATA_W-1:0] MEASUREMENT_VARIANCE_RST = 32'd32768;

   typedef enum logic [1:0] {
      KIND_GYRO,
      KIND_SEED,
      KIND_UPDATE
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic [DATA_W-1:0] sample;
   } item_type;

   typedef struct packed {
      logic [DATA_W-1:0] initial_variance;
      logic [DATA_W-1:0] motion_variance;
      logic [DATA_W-1:0] measurement_variance;
   } cfg_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL_A,
      BK_MUL_B,
      BK_MUL_C,
      BK_COMBINE,
      BK_START,
      BK_DIVIDE,
      BK_FINISH
   } back_state_type;

endpackage

`default_nettype wire

[rtl/kfr_queue.sv]
`default_nettype none

module kfr_queue (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   push,
   input  kfr_pkg::item_type                     push_item,
   input  wire                                   pop,
   output kfr_pkg::item_type                     head_item,
   output kfr_pkg::queue_status_type             status,
   output logic [kfr_pkg::QUEUE_CNT_W-1:0]       count
);
   import kfr_pkg::*;

   item_type                 mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]   count_ff;
   logic [QUEUE_CNT_W-1:0]   count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item        = mem_ff[rd_ptr_ff];
   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign status.not_empty = (count_ff != '0);
   assign count            = count_ff;

endmodule

`default_nettype wire

[rtl/kfr_front.sv]
`default_nettype none

module kfr_front (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [kfr_pkg::DATA_W-1:0]        req_tdata,  // rate_sample
   input  wire                               req_tuser,  // command
   input  kfr_pkg::queue_status_type         queue_status,
   output logic                              push,
   output kfr_pkg::item_type                 push_item
);
   import kfr_pkg::*;

   logic awaiting_ff;
   logic awaiting_in;

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      awaiting_in      = awaiting_ff;
      push_item.sample = req_tdata;
      if (req_tuser) begin
         push_item.kind = KIND_GYRO;
      end else if (awaiting_ff) begin
         push_item.kind = KIND_SEED;
      end else begin
         push_item.kind = KIND_UPDATE;
      end
      if (push && !req_tuser) begin
         awaiting_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         awaiting_ff <= 1'b1;
      end else begin
         awaiting_ff <= awaiting_in;
      end
   end

endmodule

`default_nettype wire

[rtl/kfr_div.sv]
`default_nettype none

module kfr_div (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              start,
   input  wire  [kfr_pkg::PROD_W-1:0]       dividend,
   input  wire  [kfr_pkg::DEN_W-1:0]        divisor,
   output logic                             done,
   output logic [kfr_pkg::PROD_W-1:0]       quotient
);
   import kfr_pkg::*;

   logic [PROD_W-1:0]    quo_ff;
   logic [DEN_W-1:0]     rem_ff;
   logic [DEN_W-1:0]     div_ff;
   logic [DIV_CNT_W-1:0] count_ff;
   logic                 busy_ff;
   logic                 done_ff;
   logic [DEN_W:0]       shifted;
   logic [DEN_W:0]       diff;
   logic                 ge;
   logic [DEN_W-1:0]     rem_in;

   always_comb begin
      shifted = {rem_ff, quo_ff[PROD_W-1]};
      diff    = shifted - {1'b0, div_ff};
      ge      = (shifted >= {1'b0, div_ff});
      rem_in  = ge ? diff[DEN_W-1:0] : shifted[DEN_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff  <= 1'b1;
            count_ff <= '0;
         end else if (busy_ff) begin
            count_ff <= count_ff + 1'b1;
            if (count_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         quo_ff <= dividend;
         rem_ff <= '0;
         div_ff <= divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[PROD_W-2:0], ge};
         rem_ff <= rem_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

[rtl/kfr_back.sv]
`default_nettype none

module kfr_back (
   input  wire                               clock,
   input  wire                               reset,
   input  kfr_pkg::cfg_type                  cfg,
   input  kfr_pkg::queue_status_type         queue_status,
   input  kfr_pkg::item_type                 head_item,
   output logic                              pop,
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [2*kfr_pkg::DATA_W-1:0]      rsp_tdata   // filtered_rate, estimate_variance
);
   import kfr_pkg::*;

   back_state_type    state_ff;
   back_state_type    state_in;

   logic [DATA_W-1:0] estimate_ff;
   logic [DATA_W-1:0] variance_ff;
   logic [DATA_W-1:0] prev_ff;
   logic [DATA_W-1:0] gyro_ff;
   logic [DATA_W-1:0] sample_ff;
   logic [DATA_W-1:0] m_ff;
   logic [DATA_W-1:0] p_ff;
   logic [DEN_W-1:0]  den_ff;
   logic [PROD_W-1:0] a_ff;
   logic [PROD_W-1:0] b_ff;
   logic [PROD_W-1:0] pr_ff;
   logic [PROD_W-1:0] mag_ff;
   logic              neg_ff;
   logic              rsp_valid_ff;
   logic              rsp_valid_in;
   logic [2*DATA_W-1:0] rsp_data_ff;

   logic signed [DATA_W+1:0] m_wide;
   logic [DATA_W-1:0]  m_sat;
   logic [DATA_W:0]    p_wide;
   logic [DATA_W-1:0]  p_sat;
   logic [DEN_W-1:0]   den;
   logic [DATA_W-1:0]  m_mag;
   logic [DATA_W-1:0]  z_mag;
   logic [DATA_W-1:0]  mul_x;
   logic [DATA_W-1:0]  mul_y;
   logic [PROD_W-1:0]  product;
   logic [PROD_W-1:0]  mag;
   logic               neg;
   logic               out_free;
   logic               div_start;
   logic               est_done;
   logic               var_done;
   logic [PROD_W-1:0]  est_quo;
   logic [PROD_W-1:0]  var_quo;
   logic [DATA_W-1:0]  est_sat;

   kfr_div u_est_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mag_ff),
      .divisor  (den_ff),
      .done     (est_done),
      .quotient (est_quo)
   );

   kfr_div u_var_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (pr_ff),
      .divisor  (den_ff),
      .done     (var_done),
      .quotient (var_quo)
   );

   // predict
   always_comb begin
      m_wide = $signed({{2{estimate_ff[DATA_W-1]}}, estimate_ff})
             + $signed({{2{head_item.sample[DATA_W-1]}}, head_item.sample})
             - $signed({{2{prev_ff[DATA_W-1]}}, prev_ff});
      if (m_wide > $signed(34'sh0_7FFF_FFFF)) begin
         m_sat = 32'h7FFF_FFFF;
      end else if (m_wide < $signed(34'sh3_8000_0000)) begin
         m_sat = 32'h8000_0000;
      end else begin
         m_sat = m_wide[DATA_W-1:0];
      end
      p_wide = {1'b0, variance_ff} + {1'b0, cfg.motion_variance};
      p_sat  = p_wide[DATA_W] ? '1 : p_wide[DATA_W-1:0];
      den    = {1'b0, p_sat} + {1'b0, cfg.measurement_variance};
   end

   // shared multiplier
   always_comb begin
      m_mag = m_ff[DATA_W-1] ? (~m_ff + 1'b1) : m_ff;
      z_mag = gyro_ff[DATA_W-1] ? (~gyro_ff + 1'b1) : gyro_ff;
      case (state_ff)
         BK_MUL_A: begin
            mul_x = cfg.measurement_variance;
            mul_y = m_mag;
         end
         BK_MUL_B: begin
            mul_x = p_ff;
            mul_y = z_mag;
         end
         BK_MUL_C: begin
            mul_x = p_ff;
            mul_y = cfg.measurement_variance;
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
      product = {{DATA_W{1'b0}}, mul_x} * {{DATA_W{1'b0}}, mul_y};
   end

   // sign-magnitude sum and quotient clamp
   always_comb begin
      if (m_ff[DATA_W-1] == gyro_ff[DATA_W-1]) begin
         mag = a_ff + b_ff;
         neg = m_ff[DATA_W-1];
      end else if (a_ff >= b_ff) begin
         mag = a_ff - b_ff;
         neg = m_ff[DATA_W-1];
      end else begin
         mag = b_ff - a_ff;
         neg = gyro_ff[DATA_W-1];
      end
      if (neg_ff) begin
         est_sat = (est_quo >= 64'h8000_0000) ? 32'h8000_0000 : (~est_quo[DATA_W-1:0] + 1'b1);
      end else begin
         est_sat = (est_quo >= 64'h8000_0000) ? 32'h7FFF_FFFF : est_quo[DATA_W-1:0];
      end
   end

   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: begin
            if (queue_status.not_empty && head_item.kind == KIND_UPDATE) begin
               state_in = BK_MUL_A;
            end
         end
         BK_MUL_A:   state_in = BK_MUL_B;
         BK_MUL_B:   state_in = BK_MUL_C;
         BK_MUL_C:   state_in = BK_COMBINE;
         BK_COMBINE: state_in = (den_ff == '0) ? BK_FINISH : BK_START;
         BK_START:   state_in = BK_DIVIDE;
         BK_DIVIDE: begin
            if (est_done && var_done) begin
               state_in = BK_FINISH;
            end
         end
         BK_FINISH: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:    state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      pop          = (state_ff == BK_IDLE) && queue_status.not_empty;
      div_start    = (state_ff == BK_START);
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (state_ff == BK_FINISH && out_free) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         estimate_ff  <= '0;
         variance_ff  <= INITIAL_VARIANCE_RST;
         prev_ff      <= '0;
         gyro_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (pop) begin
            case (head_item.kind)
               KIND_GYRO: gyro_ff <= head_item.sample;
               KIND_SEED: begin
                  estimate_ff <= head_item.sample;
                  prev_ff     <= head_item.sample;
                  variance_ff <= cfg.initial_variance;
               end
               default: ;
            endcase
         end
         if (state_ff == BK_COMBINE && den_ff == '0) begin
            estimate_ff <= m_ff;
            variance_ff <= '0;
         end
         if (state_ff == BK_DIVIDE && est_done && var_done) begin
            estimate_ff <= est_sat;
            variance_ff <= var_quo[DATA_W-1:0];
         end
         if (state_ff == BK_FINISH && out_free) begin
            prev_ff <= sample_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && head_item.kind == KIND_UPDATE) begin
         m_ff      <= m_sat;
         p_ff      <= p_sat;
         den_ff    <= den;
         sample_ff <= head_item.sample;
      end
      if (state_ff == BK_MUL_A) begin
         a_ff <= product;
      end
      if (state_ff == BK_MUL_B) begin
         b_ff <= product;
      end
      if (state_ff == BK_MUL_C) begin
         pr_ff <= product;
      end
      if (state_ff == BK_COMBINE) begin
         mag_ff <= mag;
         neg_ff <= neg;
      end
      if (state_ff == BK_FINISH && out_free) begin
         rsp_data_ff <= {variance_ff, estimate_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/scalar_kalman_rate_fusion.sv]
`default_nettype none

// Scalar Kalman filter fusing gyro and wheel-odometry yaw rates in signed Q16.16.
// Words enter on req_ (tuser 1 = gyro, 0 = odometry) into a two-word queue, so
// req_tready only drops when that queue is full. Gyro words and the first
// odometry word after reset leave the queue and give no response; every later
// odometry word gives one response once it is taken by an idle back end and
// has passed the shared 32x32 multiplier and then the two one-bit-per-cycle
// dividers running side by side; when both the predicted and the measurement
// variance are zero the dividers are skipped. A finished response sits in an
// output register while the next word is being worked on. csr_ready is always
// high; an initial_variance write applies at the next seeding odometry word.

module scalar_kalman_rate_fusion (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   input  wire  [kfr_pkg::DATA_W-1:0]            req_tdata,   // rate_sample
   input  wire                                   req_tuser,   // command
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   output logic [2*kfr_pkg::DATA_W-1:0]          rsp_tdata,   // filtered_rate, estimate_variance
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [kfr_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire  [kfr_pkg::DATA_W-1:0]            csr_wdata
);
   import kfr_pkg::*;

   cfg_type                cfg_ff;
   cfg_type                cfg_in;
   logic                   push;
   item_type               push_item;
   logic                   pop;
   item_type               head_item;
   queue_status_type       queue_status;
   logic [QUEUE_CNT_W-1:0] queue_count;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_INITIAL_VARIANCE:     cfg_in.initial_variance     = csr_wdata;
            CSR_MOTION_VARIANCE:      cfg_in.motion_variance      = csr_wdata;
            CSR_MEASUREMENT_VARIANCE: cfg_in.measurement_variance = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.initial_variance     <= INITIAL_VARIANCE_RST;
         cfg_ff.motion_variance      <= MOTION_VARIANCE_RST;
         cfg_ff.measurement_variance <= MEASUREMENT_VARIANCE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   kfr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_item    (push_item)
   );

   kfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .status    (queue_status),
      .count     (queue_count)
   );

   kfr_back u_back (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .queue_status (queue_status),
      .head_item    (head_item),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= QUEUE_CNT_W'(QUEUE_DEPTH))
      else $error("queue holds more words than its depth");

   a_variance_bound: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> rsp_tdata[2*DATA_W-1:DATA_W] <= cfg_ff.measurement_variance)
      else $error("posterior variance above measurement variance");
`endif

endmodule

`default_nettype wire
